// ===== design/vector4_normalize_macros.svh =====
// ============================================================================
// vector4_normalize_macros.svh
// Assertion macros shared by the vector normalizer RTL.
// ============================================================================
`ifndef VECTOR4_NORMALIZE_MACROS_SVH
`define VECTOR4_NORMALIZE_MACROS_SVH

`ifndef SYNTH
`define V4N_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define V4N_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define V4N_ASSERT_IMPL(lbl, ante, cons)
`define V4N_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/v4n_pkg.sv =====
// ============================================================================
// v4n_pkg
// Constants shared by the vector normalizer.
// ============================================================================
`default_nettype none

package v4n_pkg;

    localparam int LANES = 4;

    typedef logic [1:0] lane_idx_t;

endpackage

`default_nettype wire

// ===== design/vector4_normalize.sv =====
// ============================================================================
// vector4_normalize
// Four-component vector normalizer, exact round-to-nearest output.
// ============================================================================
// A vector is taken on every cycle with start high; busy is always low. Each
// vector gives one result, shown for exactly one cycle with done high. Done
// and the result are registered after the magnitude, square, sum and digit
// search stages, and the result is taken at the edge that follows. The digit
// search resolves one bit of every output per pipeline stage with a
// shift-and-subtract residual update. The receiver cannot stall the
// pipeline. A zero-length vector gives all-zero outputs.
`default_nettype none

`include "vector4_normalize_macros.svh"

module vector4_normalize #(
    parameter int IN_WIDTH      = 32,
    parameter int OUT_FRAC_BITS = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  signed [IN_WIDTH-1:0]       comp_x,
    input  wire  signed [IN_WIDTH-1:0]       comp_y,
    input  wire  signed [IN_WIDTH-1:0]       comp_z,
    input  wire  signed [IN_WIDTH-1:0]       comp_w,
    output logic                             done,
    output logic signed [OUT_FRAC_BITS+1:0]  unit_x,
    output logic signed [OUT_FRAC_BITS+1:0]  unit_y,
    output logic signed [OUT_FRAC_BITS+1:0]  unit_z,
    output logic signed [OUT_FRAC_BITS+1:0]  unit_w
);

    localparam int MW = 2 * IN_WIDTH;
    localparam int SW = 2 * IN_WIDTH + 1;
    localparam int RW = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 3;
    localparam int QW = OUT_FRAC_BITS + 1;
    localparam int OW = OUT_FRAC_BITS + 2;
    localparam int NS = OUT_FRAC_BITS + 1;
    localparam int L  = v4n_pkg::LANES;
    localparam logic signed [OW-1:0] UNIT_ONE = OW'(1) << OUT_FRAC_BITS;

    logic signed [IN_WIDTH-1:0] comp_in [L];

    logic                  in_valid_reg;
    logic [IN_WIDTH-1:0]   mag_reg  [L];
    logic [L-1:0]          neg_a_reg;

    logic                  sq_valid_reg;
    logic [MW-1:0]         sq_reg   [L];
    logic [L-1:0]          neg_b_reg;

    logic                  sum_valid_reg;
    logic [SW-1:0]         sum_reg;
    logic [RW-1:0]         rhs_reg  [L];
    logic [L-1:0]          neg_c_reg;

    logic                  srch_valid_reg [0:NS];
    logic                  srch_zero_reg  [0:NS];
    logic [L-1:0]          srch_neg_reg   [0:NS];
    logic signed [RW-1:0]  srch_s_reg     [0:NS];
    logic signed [RW-1:0]  srch_r_reg     [0:NS][L];
    logic signed [RW-1:0]  srch_p_reg     [0:NS][L];
    logic [QW-1:0]         srch_q_reg     [0:NS][L];

    logic                  done_reg;
    logic signed [OW-1:0]  unit_reg [L];
    logic signed [OW-1:0]  unit_next [L];

    assign comp_in[0] = comp_x;
    assign comp_in[1] = comp_y;
    assign comp_in[2] = comp_z;
    assign comp_in[3] = comp_w;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            sq_valid_reg      <= 1'b0;
            sum_valid_reg     <= 1'b0;
            srch_valid_reg[0] <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            in_valid_reg      <= start;
            sq_valid_reg      <= in_valid_reg;
            sum_valid_reg     <= sq_valid_reg;
            srch_valid_reg[0] <= sum_valid_reg;
            done_reg          <= srch_valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < L; i++)
        begin
            neg_a_reg[i] <= comp_in[i][IN_WIDTH-1];
            mag_reg[i]   <= comp_in[i][IN_WIDTH-1] ? -$unsigned(comp_in[i])
                                                   : $unsigned(comp_in[i]);
            sq_reg[i]    <= MW'(mag_reg[i]) * MW'(mag_reg[i]);
            rhs_reg[i]   <= RW'(sq_reg[i]) << (2 * OUT_FRAC_BITS + 2);
            srch_r_reg[0][i] <= $signed(rhs_reg[i]) - $signed(RW'(sum_reg));
            srch_p_reg[0][i] <= -$signed(RW'(sum_reg));
            srch_q_reg[0][i] <= '0;
        end
        neg_b_reg       <= neg_a_reg;
        neg_c_reg       <= neg_b_reg;
        sum_reg         <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2])
                           + SW'(sq_reg[3]);
        srch_neg_reg[0] <= neg_c_reg;
        srch_s_reg[0]   <= $signed(RW'(sum_reg));
        srch_zero_reg[0] <= (sum_reg == '0);
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_search
        localparam int B = OUT_FRAC_BITS - k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                srch_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                srch_valid_reg[k+1] <= srch_valid_reg[k];
            end
        end

        for (genvar i = 0; i < L; i++)
        begin : g_lane
            logic signed [RW-1:0] delta;
            logic signed [RW-1:0] trial;
            logic                 take;

            assign delta = (srch_p_reg[k][i] <<< (B + 2))
                         + (srch_s_reg[k] <<< (2 * B + 2));
            assign trial = srch_r_reg[k][i] - delta;
            assign take  = !trial[RW-1]
                           && ((B == OUT_FRAC_BITS) || !srch_q_reg[k][i][OUT_FRAC_BITS]);

            always_ff @(posedge clk)
            begin
                if (take)
                begin
                    srch_r_reg[k+1][i] <= trial;
                    srch_p_reg[k+1][i] <= srch_p_reg[k][i] + (srch_s_reg[k] <<< (B + 1));
                    srch_q_reg[k+1][i] <= srch_q_reg[k][i] | (QW'(1) << B);
                end
                else
                begin
                    srch_r_reg[k+1][i] <= srch_r_reg[k][i];
                    srch_p_reg[k+1][i] <= srch_p_reg[k][i];
                    srch_q_reg[k+1][i] <= srch_q_reg[k][i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            srch_s_reg[k+1]    <= srch_s_reg[k];
            srch_neg_reg[k+1]  <= srch_neg_reg[k];
            srch_zero_reg[k+1] <= srch_zero_reg[k];
        end
    end

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            if (srch_zero_reg[NS])
            begin
                unit_next[i] = '0;
            end
            else if (srch_neg_reg[NS][i])
            begin
                unit_next[i] = -$signed(OW'(srch_q_reg[NS][i]));
            end
            else
            begin
                unit_next[i] = $signed(OW'(srch_q_reg[NS][i]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < L; i++)
        begin
            unit_reg[i] <= unit_next[i];
        end
    end

    assign done   = done_reg;
    assign unit_x = unit_reg[0];
    assign unit_y = unit_reg[1];
    assign unit_z = unit_reg[2];
    assign unit_w = unit_reg[3];

    `V4N_ASSERT_NEXT(a_start_enters, start, in_valid_reg)
    `V4N_ASSERT_IMPL(a_done_from_search, done, $past(srch_valid_reg[NS]))
    `V4N_ASSERT_IMPL(a_unit_x_range, done, (unit_x <= UNIT_ONE) && (unit_x >= -UNIT_ONE))

endmodule

`default_nettype wire
